FILE: design/wfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfr_pkg;

   localparam int unsigned WEEK_LEN    = 7;
   localparam int unsigned MONTHS      = 12;
   localparam int unsigned YEAR_MAX    = 9999;
   localparam int unsigned RECIP_100   = 5243;   // floor(2^19 / 100) + 1
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned HUNDRED     = 100;
   localparam int unsigned YEAR_DAYS   = 365;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   // days from March 1 to the first of the month, year starting in March
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      case (m) inside
         4'd2:                      r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
         default:                   r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/weekday_from_reference_date.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | ports                         | word
// req     | in  | req_tvalid/tready/tdata[55:0] | two dates and reference weekday
// rsp     | out | rsp_tvalid/tready/tdata[31:0] | weekday, span, earlier, error
//
// From accept to rsp_tvalid, the reference date, then the query date, each take five
// passes through one shared 18x15 multiply-accumulate unit (divide by 100, leap check,
// divide by 100, 365 * year, day terms), then magnitude and weekday.
// req_tready is low while an item is in work; the result sits in an output
// register, so a new word is taken while the previous result waits.
// Synchronous active-high reset clears the sequencer and rsp_tvalid.

module weekday_from_reference_date (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // ref_day, ref_month, ref_year, ref_weekday, query_day, query_month, query_year
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // query_weekday, day_span, query_earlier, date_error
   output logic [31:0]      rsp_tdata
);

   import wfr_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_QY   = 3'd1;
   localparam logic [2:0] ST_CHK  = 3'd2;
   localparam logic [2:0] ST_QYY  = 3'd3;
   localparam logic [2:0] ST_YR   = 3'd4;
   localparam logic [2:0] ST_K    = 3'd5;
   localparam logic [2:0] ST_ABS  = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   localparam logic signed [17:0] A_RECIP = 18'(RECIP_100);
   localparam logic signed [17:0] A_HUND  = 18'(HUNDRED);
   localparam logic signed [17:0] A_YEAR  = 18'(YEAR_DAYS);

   logic [2:0]         state_ff, state_in;
   logic               side_ff, side_in;
   date_type           rdate_ff, rdate_in;
   date_type           qdate_ff, qdate_in;
   logic [2:0]         rwd_ff, rwd_in;
   logic [7:0]         q_ff, q_in;
   logic signed [23:0] acc_ff, acc_in;
   logic               err_ff, err_in;
   logic [21:0]        span_ff, span_in;
   logic               early_ff, early_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   date_type           cur;
   logic [13:0]        cur_yy;
   logic [12:0]        k;
   logic signed [17:0] k_s;
   logic signed [17:0] op_a;
   logic [13:0]        op_b;
   logic signed [23:0] op_c;
   logic signed [32:0] mac;
   logic               hund, leap, bad;
   logic [4:0]         mlen;
   logic [2:0]         wd;
   logic               accept, out_free;
   logic signed [23:0] acc_neg;

   wfr_mac u_mac (
      .op_a (op_a),
      .op_b (op_b),
      .op_c (op_c),
      .mac  (mac)
   );

   wfr_wkday u_wkday (
      .span    (span_ff),
      .earlier (early_ff),
      .ref_wd  (rwd_ff),
      .wd      (wd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cur    = side_ff ? qdate_ff : rdate_ff;
   assign cur_yy = (cur.month <= 4'd2) ? cur.year - 14'd1 : cur.year;
   assign k      = {1'b0, cur_yy[13:2]} - {5'b0, q_ff} + {7'b0, q_ff[7:2]}
                 + {4'b0, month_offset(cur.month)} + {8'b0, cur.day};
   assign k_s    = $signed({5'b0, k});

   // reference terms are subtracted, query terms added
   always_comb begin
      op_a = A_RECIP;
      op_b = cur.year;
      op_c = '0;
      unique case (state_ff)
         ST_QY: begin
            op_a = A_RECIP;
            op_b = cur.year;
         end
         ST_CHK: begin
            op_a = A_HUND;
            op_b = {6'b0, q_ff};
         end
         ST_QYY: begin
            op_a = A_RECIP;
            op_b = cur_yy;
         end
         ST_YR: begin
            op_a = side_ff ? A_YEAR : -A_YEAR;
            op_b = cur_yy;
            op_c = acc_ff;
         end
         ST_K: begin
            op_a = side_ff ? k_s : -k_s;
            op_b = 14'd1;
            op_c = acc_ff;
         end
         default: begin
            op_a = A_RECIP;
            op_b = cur.year;
         end
      endcase
   end

   assign hund = (mac == $signed({19'b0, cur.year}));
   assign leap = (cur.year[1:0] == 2'b00) && (!hund || q_ff[1:0] == 2'b00);
   assign mlen = month_len(cur.month, leap);
   assign bad  = (cur.month == 4'd0) || (cur.month > 4'(MONTHS))
              || (cur.year == 14'd0) || (cur.year > 14'(YEAR_MAX))
              || (cur.day == 5'd0) || (cur.day > mlen);
   assign acc_neg = -acc_ff;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      rdate_in     = rdate_ff;
      qdate_in     = qdate_ff;
      rwd_in       = rwd_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      span_in      = span_ff;
      early_in     = early_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rdate_in = '{year: req_tdata[22:9], month: req_tdata[8:5],
                            day: req_tdata[4:0]};
               rwd_in   = req_tdata[25:23];
               qdate_in = '{year: req_tdata[48:35], month: req_tdata[34:31],
                            day: req_tdata[30:26]};
               side_in  = 1'b0;
               acc_in   = '0;
               err_in   = 1'b0;
               state_in = ST_QY;
            end
         end
         ST_QY: begin
            q_in     = mac[RECIP_SHIFT +: 8];
            state_in = ST_CHK;
         end
         ST_CHK: begin
            err_in   = err_ff | bad;
            state_in = ST_QYY;
         end
         ST_QYY: begin
            q_in     = mac[RECIP_SHIFT +: 8];
            state_in = ST_YR;
         end
         ST_YR: begin
            acc_in   = mac[23:0];
            state_in = ST_K;
         end
         ST_K: begin
            acc_in = mac[23:0];
            if (side_ff) begin
               state_in = ST_ABS;
            end else begin
               side_in  = 1'b1;
               state_in = ST_QY;
            end
         end
         ST_ABS: begin
            early_in = acc_ff[23];
            span_in  = acc_ff[23] ? acc_neg[21:0] : acc_ff[21:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = err_ff ? {5'b0, 1'b1, 26'b0}
                                     : {5'b0, 1'b0, early_ff, span_ff, wd};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rdate_ff    <= rdate_in;
      qdate_ff    <= qdate_in;
      rwd_ff      <= rwd_in;
      q_ff        <= q_in;
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      span_ff     <= span_in;
      early_ff    <= early_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("accepted a word while busy");

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tdata[25:0] == 26'd0)
      else $error("error result carries nonzero fields");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7)
      else $error("weekday out of range");

   a_earlier_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> rsp_tdata[24:3] != 22'd0)
      else $error("earlier query with zero span");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_FIN)
      else $error("result raised outside final step");

endmodule

`default_nettype wire

FILE: design/wfr_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module wfr_mac (
   input  wire logic signed [17:0] op_a,
   input  wire logic        [13:0] op_b,
   input  wire logic signed [23:0] op_c,
   output logic signed      [32:0] mac
);

   logic signed [32:0] prod;

   assign prod = op_a * $signed({1'b0, op_b});
   assign mac  = prod + {{9{op_c[23]}}, op_c};

endmodule

`default_nettype wire

FILE: design/wfr_wkday.sv
`timescale 1ns / 1ps
`default_nettype none

module wfr_wkday (
   input  wire logic [21:0] span,
   input  wire logic        earlier,
   input  wire logic [2:0]  ref_wd,
   output logic [2:0]       wd
);

   import wfr_pkg::*;

   localparam logic [3:0] WEEK = 4'(WEEK_LEN);

   // 8 == 1 mod 7: fold octal digits
   always_comb begin
      logic [23:0] padded;
      logic [5:0]  dsum;
      logic [3:0]  fold;
      logic [3:0]  rem;
      logic [3:0]  base;
      logic [3:0]  t;
      padded = {2'b00, span};
      dsum   = '0;
      for (int i = 0; i < 8; i++) begin
         dsum = dsum + {3'b000, padded[3*i +: 3]};
      end
      fold = {1'b0, dsum[5:3]} + {1'b0, dsum[2:0]};
      rem  = (fold >= WEEK) ? fold - WEEK : fold;
      base = (ref_wd == 3'd7) ? 4'd0 : {1'b0, ref_wd};
      t    = earlier ? base + WEEK - rem : base + rem;
      wd   = (t >= WEEK) ? 3'(t - WEEK) : t[2:0];
   end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import wfr_pkg::*;

   typedef enum logic [2:0] {
      MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY, SATURDAY, SUNDAY, WRAP_MONDAY
   } weekday_type;

   typedef struct packed {
      logic [6:0] pad;
      date_type   query_date;
      logic [2:0] ref_weekday;
      date_type   ref_date;
   } date_pair_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic        date_error;
      logic        query_earlier;
      logic [21:0] day_span;
      logic [2:0]  query_weekday;
   } weekday_result_type;

   typedef struct packed {
      date_pair_type      word;
      logic               typed;
      weekday_result_type known;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   weekday_result_type expected_q[$];
   dir_row_type        dir_rows[$];
   int                 mismatches = 0;
   bit                 sender_steady = 1'b0;
   bit                 receiver_steady = 1'b0;

   weekday_from_reference_date u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic bit is_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
         2:              return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:    return 30;
         default:        return 31;
      endcase
   endfunction

   function automatic bit date_valid(date_type d);
      if (d.month < 1 || d.month > MONTHS) return 1'b0;
      if (d.year < 1 || d.year > YEAR_MAX) return 1'b0;
      return d.day >= 1 && d.day <= days_in_month(d.month, d.year);
   endfunction

   // day count with the year starting in March so the leap day falls last
   function automatic int unsigned day_count(date_type d);
      int unsigned y, mp;
      y = d.year;
      if (d.month <= 2) begin
         y = y - 1;
         mp = d.month + 9;
      end else begin
         mp = d.month - 3;
      end
      return 365 * y + y / 4 - y / 100 + y / 400 + (153 * mp + 2) / 5 + d.day - 1;
   endfunction

   function automatic weekday_result_type predict_weekday(date_pair_type w);
      weekday_result_type r;
      int unsigned        nr, nq, span, wd;
      r = '0;
      if (!date_valid(w.ref_date) || !date_valid(w.query_date)) begin
         r.date_error = 1'b1;
         return r;
      end
      nr = day_count(w.ref_date);
      nq = day_count(w.query_date);
      wd = w.ref_weekday % WEEK_LEN;
      if (nq < nr) begin
         span = nr - nq;
         r.query_earlier = 1'b1;
         wd = (wd + WEEK_LEN - span % WEEK_LEN) % WEEK_LEN;
      end else begin
         span = nq - nr;
         wd = (wd + span % WEEK_LEN) % WEEK_LEN;
      end
      r.day_span = span[21:0];
      r.query_weekday = wd[2:0];
      return r;
   endfunction

   function automatic date_pair_type pair(int rd, int rm, int ry, int rw, int qd, int qm, int qy);
      date_pair_type w;
      w = '0;
      w.ref_date.day = rd[4:0];
      w.ref_date.month = rm[3:0];
      w.ref_date.year = ry[13:0];
      w.ref_weekday = rw[2:0];
      w.query_date.day = qd[4:0];
      w.query_date.month = qm[3:0];
      w.query_date.year = qy[13:0];
      return w;
   endfunction

   function automatic weekday_result_type known(int wd, int span, bit earlier, bit err);
      weekday_result_type r;
      r = '0;
      r.query_weekday = wd[2:0];
      r.day_span = span[21:0];
      r.query_earlier = earlier;
      r.date_error = err;
      return r;
   endfunction

   task automatic add_row(date_pair_type w, bit typed, weekday_result_type k);
      dir_rows.push_back('{word: w, typed: typed, known: k});
   endtask

   // mostly short, now and then long
   function automatic int pick_stretch();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return $urandom_range(1, 3);
      if (sel < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic int unsigned pick_year();
      int unsigned y;
      case ($urandom_range(0, 5))
         0:       y = $urandom_range(1, YEAR_MAX);
         1:       y = $urandom_range(0, 99) * 100 + $urandom_range(0, 2);
         2:       y = $urandom_range(1, 30);
         3:       y = $urandom_range(8192, YEAR_MAX);
         4:       y = $urandom_range(YEAR_MAX - 9, YEAR_MAX);
         default: y = $urandom_range(1500, 2500);
      endcase
      return (y < 1) ? 1 : (y > YEAR_MAX) ? YEAR_MAX : y;
   endfunction

   function automatic date_type valid_date(int unsigned y);
      date_type d;
      d.year = y[13:0];
      d.month = 4'($urandom_range(1, MONTHS));
      d.day = 5'($urandom_range(1, days_in_month(d.month, d.year)));
      return d;
   endfunction

   function automatic date_type noisy_date();
      date_type d;
      d.year = 14'($urandom_range(0, 16383));
      d.month = 4'($urandom_range(0, 15));
      d.day = 5'($urandom_range(0, 31));
      return d;
   endfunction

   function automatic date_type broken_date();
      date_type     d;
      int unsigned  len;
      d = valid_date(pick_year());
      len = days_in_month(d.month, d.year);
      case ($urandom_range(0, 3))
         0:       d.day = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
         1:       d.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
         2:       d.year = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(10000, 16383));
         default: begin
            d.month = 4'd2;
            d.day = 5'd29 + 5'($urandom_range(0, 2));
            d.year = 14'($urandom_range(1, 2499) * 4 + 1);
         end
      endcase
      return d;
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type w;
      int unsigned   y;
      int            sel;
      w = '0;
      w.ref_weekday = 3'($urandom_range(0, 7));
      w.ref_date = valid_date(pick_year());
      if ($urandom_range(0, 9) < 4) begin
         y = w.ref_date.year + $urandom_range(0, 4);
         y = (y < 3) ? 1 : y - 2;
         if (y > YEAR_MAX) y = YEAR_MAX;
         w.query_date = valid_date(y);
      end else begin
         w.query_date = valid_date(pick_year());
      end
      sel = $urandom_range(0, 99);
      if (sel < 5) w.ref_date = broken_date();
      else if (sel < 10) w.query_date = broken_date();
      else if (sel < 14) w.ref_date = noisy_date();
      else if (sel < 18) w.query_date = noisy_date();
      else if (sel < 20) begin
         w.ref_date = noisy_date();
         w.query_date = noisy_date();
      end else if (sel < 23) w.query_date = w.ref_date;
      return w;
   endfunction

   task automatic send_word(date_pair_type w, bit typed, weekday_result_type k);
      req_tdata <= w;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(typed ? k : predict_weekday(w));
   endtask

   task automatic sender_gap();
      int n;
      n = (sender_steady || $urandom_range(0, 1)) ? 0 : pick_stretch();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // result side: random stalls, checks on each accepted word
   initial begin
      int                 hold;
      weekday_result_type got, exp;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word %h", rsp_tdata);
            end else begin
               exp = expected_q.pop_front();
               if (got.query_weekday !== exp.query_weekday || got.day_span !== exp.day_span ||
                   got.query_earlier !== exp.query_earlier ||
                   got.date_error !== exp.date_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: weekday %0d/%0d span %0d/%0d earlier %0b/%0b error %0b/%0b",
                              exp.query_weekday, got.query_weekday, exp.day_span, got.day_span,
                              exp.query_earlier, got.query_earlier, exp.date_error,
                              got.date_error);
               end
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!receiver_steady && $urandom_range(0, 4) == 0) begin
            hold = pick_stretch() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int waited;
      add_row(pair(1, 1, 1, MONDAY, 1, 1, 1), 1'b1, known(MONDAY, 0, 0, 0));
      add_row(pair(31, 12, 9999, SUNDAY, 31, 12, 9999), 1'b1, known(SUNDAY, 0, 0, 0));
      add_row(pair(1, 1, 1, MONDAY, 31, 12, 9999), 1'b0, '0);
      add_row(pair(31, 12, 9999, FRIDAY, 1, 1, 1), 1'b0, '0);
      add_row(pair(15, 6, 2024, WRAP_MONDAY, 15, 6, 2024), 1'b1, known(MONDAY, 0, 0, 0));
      add_row(pair(10, 0, 2000, TUESDAY, 1, 1, 2000), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(10, 13, 2000, TUESDAY, 1, 1, 2000), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 2000, TUESDAY, 10, 15, 2000), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(0, 5, 2000, TUESDAY, 1, 1, 2000), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 2000, TUESDAY, 31, 4, 2000), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 2000, TUESDAY, 31, 11, 1999), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(29, 2, 1900, WEDNESDAY, 1, 3, 1900), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 2000, SATURDAY, 29, 2, 2000), 1'b0, '0);
      add_row(pair(1, 3, 2023, WEDNESDAY, 29, 2, 2023), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(29, 2, 2024, THURSDAY, 1, 1, 2024), 1'b0, '0);
      add_row(pair(1, 1, 0, MONDAY, 1, 1, 1), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 1, MONDAY, 1, 1, 10000), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 1, MONDAY, 31, 12, 16383), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(31, 15, 16383, WRAP_MONDAY, 0, 0, 0), 1'b1, known(MONDAY, 0, 0, 1));
      add_row(pair(1, 1, 2000, SATURDAY, 1, 1, 2001), 1'b0, '0);
      add_row(pair(28, 2, 2100, FRIDAY, 1, 3, 2100), 1'b0, '0);
      add_row(pair(1, 3, 2000, WEDNESDAY, 29, 2, 2000), 1'b0, '0);
      add_row(pair(31, 12, 1999, FRIDAY, 1, 1, 2000), 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].known);
         sender_gap();
      end

      for (int i = 0; i < 1300; i++) begin
         sender_steady = (i / 100) % 4 == 1;
         receiver_steady = (i / 100) % 4 == 2;
         if (i == 650) begin
            req_tvalid <= 1'b0;
            wait (expected_q.size() == 0);
            @(posedge clock);
         end
         send_word(random_pair(), 1'b0, '0);
         sender_gap();
      end
      req_tvalid <= 1'b0;
      receiver_steady = 1'b0;

      waited = 0;
      while (expected_q.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
